@@ hdl/ryuv_pkg.sv @@
// ----------------------------------------------------------------------------
// ryuv_pkg
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryuv_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH  = MAX_WIDTH / 2;
  localparam int IDX_W       = $clog2(LINE_DEPTH);

  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 8;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd992;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd672;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int PSUM_W      = 9;
  localparam int ENTRY_W     = 3 * PSUM_W;

  // One classified pixel word from the front to the back
  typedef struct packed {
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [PSUM_W-1:0] sum_red;
    logic [PSUM_W-1:0] sum_green;
    logic [PSUM_W-1:0] sum_blue;
    logic              pair;      // odd column: pair of pixels complete
    logic              odd_row;
    logic [IDX_W-1:0]  idx;
    logic              frame_end;
  } pix_word_t;

endpackage

@@ hdl/ryuv_front.sv @@
// ----------------------------------------------------------------------------
// ryuv_front
// Accepts pixels, tracks raster position and forms pair sums of each word.
// ----------------------------------------------------------------------------
module ryuv_front import ryuv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output pix_word_t            push_word
);

  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       prev_red_r, prev_green_r, prev_blue_r;
  logic [FW_W-1:0]  w_even;
  logic [FH_W-1:0]  h_even;
  logic [COL_W:0]   eff_w;
  logic [ROW_W:0]   eff_h;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             cfg_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT);

  // Effective geometry: even, at least two, saturated to the maximum
  always_comb begin
    w_even = {frame_width_r[FW_W-1:1], 1'b0};
    h_even = {frame_height_r[FH_W-1:1], 1'b0};
    if (w_even == '0) begin
      eff_w = (COL_W+1)'(2);
    end else if (32'(w_even) > 32'(MAX_WIDTH)) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W+1)'(w_even);
    end
    if (h_even == '0) begin
      eff_h = (ROW_W+1)'(2);
    end else if (32'(h_even) > 32'(MAX_HEIGHT)) begin
      eff_h = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (ROW_W+1)'(h_even);
    end
  end

  always_comb begin
    col_inc = {1'b0, col_r} + 1'b1;
    row_inc = {1'b0, row_r} + 1'b1;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  always_comb begin
    push_word.red       = in_red;
    push_word.green     = in_green;
    push_word.blue      = in_blue;
    push_word.sum_red   = {1'b0, prev_red_r}   + {1'b0, in_red};
    push_word.sum_green = {1'b0, prev_green_r} + {1'b0, in_green};
    push_word.sum_blue  = {1'b0, prev_blue_r}  + {1'b0, in_blue};
    push_word.pair      = col_r[0];
    push_word.odd_row   = row_r[0];
    push_word.idx       = col_r[COL_W-1:1];
    push_word.frame_end = (col_inc == eff_w) && (row_inc == eff_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
      col_r          <= '0;
      row_r          <= '0;
      prev_red_r     <= '0;
      prev_green_r   <= '0;
      prev_blue_r    <= '0;
    end else begin
      if (cfg_hit) begin
        // a register write restarts the frame
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_width_r <= cfg_data[FW_W-1:0];
        end else begin
          frame_height_r <= cfg_data[FH_W-1:0];
        end
        col_r <= '0;
        row_r <= '0;
      end else if (push) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (push) begin
        prev_red_r   <= in_red;
        prev_green_r <= in_green;
        prev_blue_r  <= in_blue;
      end
    end
  end

endmodule

@@ hdl/ryuv_queue.sv @@
// ----------------------------------------------------------------------------
// ryuv_queue
// Short first-in first-out queue of classified pixel words.
// ----------------------------------------------------------------------------
module ryuv_queue import ryuv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pix_word_t push_word,
  input  logic      pop,
  output pix_word_t head_word,
  output logic      full,
  output logic      empty
);

  pix_word_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_word = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ryuv_back.sv @@
// ----------------------------------------------------------------------------
// ryuv_back
// Luma, line store and chroma pipeline with a registered output word.
// ----------------------------------------------------------------------------
module ryuv_back import ryuv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pix_word_t  head_word,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_luma,
  output logic       out_chroma_valid,
  output logic [7:0] out_cb_value,
  output logic [7:0] out_cr_value,
  output logic       out_frame_end
);

  logic [ENTRY_W-1:0] line_mem [LINE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // stage 1
  logic              s1_valid_r;
  logic [15:0]       s1_luma_sum_r;
  logic [PSUM_W-1:0] s1_sum_red_r, s1_sum_green_r, s1_sum_blue_r;
  logic              s1_chroma_r, s1_frame_end_r;
  // stage 2
  logic              s2_valid_r;
  logic [7:0]        s2_luma_r;
  logic [7:0]        s2_avg_red_r, s2_avg_green_r, s2_avg_blue_r;
  logic              s2_chroma_r, s2_frame_end_r;
  // output
  logic              out_valid_r;
  logic [7:0]        out_luma_r, out_cb_r, out_cr_r;
  logic              out_chroma_r, out_frame_end_r;

  logic              adv_out, adv2;
  logic [15:0]       luma_sum;
  logic [PSUM_W:0]   blk_red, blk_green, blk_blue;
  logic [16:0]       cb_t, cr_t;

  assign adv_out = s2_valid_r && (!out_valid_r || out_ready);
  assign adv2    = s1_valid_r && (!s2_valid_r || adv_out);
  assign pop     = !q_empty && (!s1_valid_r || adv2);

  assign luma_sum = 16'(head_word.red) * 16'd66 + 16'(head_word.green) * 16'd129 +
                    16'(head_word.blue) * 16'd25 + 16'd128;

  // even row writes the pair sums, odd row reads them back
  always_ff @(posedge clk) begin
    if (pop && head_word.pair && !head_word.odd_row) begin
      line_mem[head_word.idx] <= {head_word.sum_red, head_word.sum_green,
                                  head_word.sum_blue};
    end
    if (pop) begin
      rd_data_r <= line_mem[head_word.idx];
    end
  end

  always_comb begin
    blk_red   = {1'b0, s1_sum_red_r}   + {1'b0, rd_data_r[3*PSUM_W-1:2*PSUM_W]};
    blk_green = {1'b0, s1_sum_green_r} + {1'b0, rd_data_r[2*PSUM_W-1:PSUM_W]};
    blk_blue  = {1'b0, s1_sum_blue_r}  + {1'b0, rd_data_r[PSUM_W-1:0]};
  end

  // offset 128 + 32768 keeps both sums non-negative and below 2^16
  always_comb begin
    cb_t = 17'd32896 + 17'(s2_avg_blue_r) * 17'd112
         - 17'(s2_avg_red_r) * 17'd38 - 17'(s2_avg_green_r) * 17'd74;
    cr_t = 17'd32896 + 17'(s2_avg_red_r) * 17'd112
         - 17'(s2_avg_green_r) * 17'd94 - 17'(s2_avg_blue_r) * 17'd18;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_luma_sum_r  <= luma_sum;
      s1_sum_red_r   <= head_word.sum_red;
      s1_sum_green_r <= head_word.sum_green;
      s1_sum_blue_r  <= head_word.sum_blue;
      s1_chroma_r    <= head_word.pair && head_word.odd_row;
      s1_frame_end_r <= head_word.frame_end;
    end
    if (adv2) begin
      s2_luma_r       <= s1_luma_sum_r[15:8] + 8'd16;
      s2_avg_red_r    <= blk_red[PSUM_W:2];
      s2_avg_green_r  <= blk_green[PSUM_W:2];
      s2_avg_blue_r   <= blk_blue[PSUM_W:2];
      s2_chroma_r     <= s1_chroma_r;
      s2_frame_end_r  <= s1_frame_end_r;
    end
    if (adv_out) begin
      out_luma_r      <= s2_luma_r;
      out_chroma_r    <= s2_chroma_r;
      out_cb_r        <= s2_chroma_r ? (cb_t[16] ? 8'd255 : cb_t[15:8]) : 8'd0;
      out_cr_r        <= s2_chroma_r ? (cr_t[16] ? 8'd255 : cr_t[15:8]) : 8'd0;
      out_frame_end_r <= s2_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (adv2) begin
        s1_valid_r <= 1'b0;
      end
      if (adv2) begin
        s2_valid_r <= 1'b1;
      end else if (adv_out) begin
        s2_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_luma_r;
  assign out_chroma_valid = out_chroma_r;
  assign out_cb_value     = out_cb_r;
  assign out_cr_value     = out_cr_r;
  assign out_frame_end    = out_frame_end_r;

endmodule

@@ hdl/rgb_to_yuv420_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// BT.601 limited-range RGB to YCbCr 4:2:0 converter, one pixel per clock.
//
// Pixels enter in raster order on the in_ channel (in_red, in_green,
// in_blue) with valid/ready. Each accepted pixel gives one output word on
// the out_ channel: its luma, and on the bottom-right pixel of every 2x2
// block chroma_valid with the block's Cb and Cr. frame_end marks the last
// pixel of a frame.
// The cfg_ channel writes frame_width (index 0) and frame_height (index 1);
// cfg_ready is always high and a write to either restarts the frame. Write
// only while the block is idle.
// An accepted pixel passes the queue, stage 1, stage 2 and output register.
// Throughput: one pixel per cycle when not stalled, set by the line store of
// pair sums (read each word, written on even-row pairs) and the three-stage
// back pipeline. Reset clears position, previous pixel and all pipeline
// valids; geometry returns to 992 x 672. The line store needs no clearing.
// When the receiver stalls, the pipeline holds and the four-word queue
// fills; in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_converter import ryuv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_luma,
  output logic                  out_chroma_valid,
  output logic [7:0]            out_cb_value,
  output logic [7:0]            out_cr_value,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pix_word_t push_word, head_word;
  logic      push, pop, q_full, q_empty;

  ryuv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  ryuv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  ryuv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_word        (head_word),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_cb_value     (out_cb_value),
    .out_cr_value     (out_cr_value),
    .out_frame_end    (out_frame_end)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB to YCbCr 4:2:0 converter. Pixels are sent
// in raster order over the in_ channel, frame geometry is set through the
// cfg_ channel, and every output word is checked against a bit-exact
// prediction of luma, block chroma and the end-of-frame flag. Both sides
// stall at random; geometry runs from the smallest frame to the largest.
// ----------------------------------------------------------------------------
module testbench;
  import ryuv_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;
  localparam int                   RANDOM_PIXELS   = 200;

  typedef struct packed {
    logic [7:0] luma;
    logic       has_chroma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       last_of_frame;
  } yuv_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_luma;
  logic                  out_chroma_valid;
  logic [7:0]            out_cb_value;
  logic [7:0]            out_cr_value;
  logic                  out_frame_end;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the converter's geometry and position
  logic [FW_W-1:0]     width_reg  = FRAME_WIDTH_RESET;
  logic [FH_W-1:0]     height_reg = FRAME_HEIGHT_RESET;
  int unsigned         col_pos    = 0;
  int unsigned         row_pos    = 0;
  logic [23:0]         last_rgb   = '0;
  logic [ENTRY_W-1:0]  pair_sums [LINE_DEPTH];

  yuv_word_t pending_yuv [$];
  int        mismatch_count = 0;
  bit        idle_en        = 1'b1;
  int        ready_hold     = 0;

  rgb_to_yuv420_converter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_cb_value     (out_cb_value),
    .out_cr_value     (out_cr_value),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic int unsigned even_dim(input int unsigned value, input int unsigned limit);
    int unsigned dim;
    dim = value & 32'hFFFF_FFFE;
    if (dim == 0) dim = 2;
    if (dim > limit) dim = limit;
    return dim;
  endfunction

  function automatic logic [7:0] clip_byte(input int value);
    if (value > 255) return 8'hFF;
    if (value < 0) return 8'h00;
    return value[7:0];
  endfunction

  // Floor shift of a biased chroma sum; the bias keeps the shift non-negative
  function automatic logic [7:0] block_chroma(input int sum);
    int biased;
    biased = sum + 128 + 32768;
    if (biased < 0) biased = 0;
    return clip_byte(biased >>> 8);
  endfunction

  task automatic predict_yuv(input logic [23:0] rgb);
    int unsigned w, h, col, row, idx;
    int          r, g, b, sr, sg, sb, ar, ag, ab;
    logic [ENTRY_W-1:0] entry;
    yuv_word_t   word;
    w   = even_dim(width_reg, MAX_WIDTH);
    h   = even_dim(height_reg, MAX_HEIGHT);
    col = (col_pos >= w) ? 0 : col_pos;
    row = (row_pos >= h) ? 0 : row_pos;
    r   = int'(rgb[23:16]);
    g   = int'(rgb[15:8]);
    b   = int'(rgb[7:0]);
    word = '0;
    word.luma = clip_byte(16 + ((66 * r + 129 * g + 25 * b + 128) >>> 8));
    if (col % 2 == 1) begin
      sr  = int'(last_rgb[23:16]) + r;
      sg  = int'(last_rgb[15:8]) + g;
      sb  = int'(last_rgb[7:0]) + b;
      idx = (col >> 1) % LINE_DEPTH;
      if (row % 2 == 0) begin
        pair_sums[idx] = {9'(sr), 9'(sg), 9'(sb)};
      end else begin
        entry = pair_sums[idx];
        ar = (sr + int'(entry[26:18])) >>> 2;
        ag = (sg + int'(entry[17:9])) >>> 2;
        ab = (sb + int'(entry[8:0])) >>> 2;
        word.has_chroma = 1'b1;
        word.cb = block_chroma(-38 * ar - 74 * ag + 112 * ab);
        word.cr = block_chroma(112 * ar - 94 * ag - 18 * ab);
      end
    end
    last_rgb = rgb;
    word.last_of_frame = (col == w - 1) && (row == h - 1);
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    pending_yuv.push_back(word);
  endtask

  // Receiver: random stall bursts while idling is enabled
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (ready_hold > 0) ready_hold--;
      else if (idle_en && $urandom_range(0, 7) == 0) ready_hold = $urandom_range(1, 6);
      out_ready <= (ready_hold == 0);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    yuv_word_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_luma, out_chroma_valid, out_cb_value, out_cr_value, out_frame_end};
      if (pending_yuv.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: luma %0d chroma %0b cb %0d cr %0d end %0b",
                   got.luma, got.has_chroma, got.cb, got.cr, got.last_of_frame);
      end else begin
        want = pending_yuv.pop_front();
        if (got.luma !== want.luma || got.has_chroma !== want.has_chroma ||
            got.cb !== want.cb || got.cr !== want.cr ||
            got.last_of_frame !== want.last_of_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp luma %0d chroma %0b cb %0d cr %0d end %0b, %s",
                     want.luma, want.has_chroma, want.cb, want.cr, want.last_of_frame,
                     $sformatf("got luma %0d chroma %0b cb %0d cr %0d end %0b",
                               got.luma, got.has_chroma, got.cb, got.cr,
                               got.last_of_frame));
        end
      end
    end
  end

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [23:0] random_rgb();
    return {pick_level(), pick_level(), pick_level()};
  endfunction

  task automatic send_pixel(input logic [23:0] rgb);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= rgb[23:16];
    in_green <= rgb[15:8];
    in_blue  <= rgb[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_yuv(rgb);
  endtask

  // Drop valid, wait for every word to come back, then let the pipe empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_yuv.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (index)
      REG_FRAME_WIDTH: begin
        width_reg = value[FW_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_reg = value[FH_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(random_rgb());
  endtask

  task automatic send_block(input logic [23:0] p0, input logic [23:0] p1,
                            input logic [23:0] p2, input logic [23:0] p3);
    send_pixel(p0);
    send_pixel(p1);
    send_pixel(p2);
    send_pixel(p3);
  endtask

  // Default geometry straight out of reset
  task automatic test_reset_geometry();
    idle_en = 1'b1;
    send_random(30);
  endtask

  // 2x2 frames (zero width, height one) with saturated colours in each block
  task automatic test_colour_extremes();
    set_geometry(13'd0, 13'd1);
    send_block(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_block(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_block(24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000);
    send_block(24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00);
    send_block(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF);
    send_block(24'hFF00FF, 24'h00FF00, 24'h000000, 24'hFFFFFF);
  endtask

  // Odd register values lose their low bit; unknown indexes must not restart
  task automatic test_odd_registers();
    set_geometry(13'd7, 13'd5);
    send_random(10);
    write_reg(REG_UNUSED_LOW, 13'h1FFF);
    write_reg(REG_UNUSED_HIGH, 13'h0000);
    send_random(20);
  endtask

  task automatic test_max_width();
    idle_en = 1'b0;
    set_geometry(13'h1FFF, 13'd2);
    send_random(30);
  endtask

  task automatic test_max_height();
    idle_en = 1'b0;
    set_geometry(13'd2, 13'h1FFF);
    send_random(30);
  endtask

  task automatic test_random_frames();
    int sent, count, pixels;
    logic [CFG_DATA_W-1:0] w, h;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 40)) : 13'($urandom_range(2, 16));
      h = 13'($urandom_range(0, 9));
      set_geometry(w, h);
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_HIGH)),
                  CFG_DATA_W'($urandom_range(0, 8191)));
      idle_en = ($urandom_range(0, 3) != 0);
      pixels = even_dim(w, MAX_WIDTH) * even_dim(h, MAX_HEIGHT);
      count = pixels + $urandom_range(0, pixels);
      if (count > 60) count = 60;
      send_random(count);
      sent += count;
    end
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_geometry(13'd10, 13'd4);
    send_random(50);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_colour_extremes();
    test_odd_registers();
    test_max_width();
    test_max_height();
    test_random_frames();
    test_steady_stream();

    settle_block();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_yuv.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ryuv_pkg.sv
hdl/ryuv_front.sv
hdl/ryuv_queue.sv
hdl/ryuv_back.sv
hdl/rgb_to_yuv420_converter.sv
tb/testbench.sv
